/* rtl/dcic_pkg.sv */
`timescale 1ns / 1ps
// dcic_pkg: word types, action codes and priority tables shared by the
// cascaded interrupt controller modules. No dependencies.
package dcic_pkg;

  localparam logic [4:0] NO_LINE = 5'd16;

  localparam logic [15:0] MASK_RESET   = 16'hFEF8;
  localparam logic [4:0]  MASTER_VBASE = 5'(8'h08 >> 3);
  localparam logic [4:0]  SLAVE_VBASE  = 5'(8'h70 >> 3);

  typedef enum logic [2:0] {
    ACT_WR_CMD   = 3'd0,
    ACT_WR_DATA  = 3'd1,
    ACT_RD_CMD   = 3'd2,
    ACT_RD_DATA  = 3'd3,
    ACT_RAISE    = 3'd4,
    ACT_DROP     = 3'd5,
    ACT_SET_MASK = 3'd6,
    ACT_ACK      = 3'd7
  } action_e;

  // Position of each init word in the data-port sequence.
  typedef enum logic [1:0] {
    IW_NONE = 2'd0,
    IW_ICW2 = 2'd1,
    IW_ICW3 = 2'd2,
    IW_ICW4 = 2'd3
  } init_word_e;

  // Fixed priority: master 0..2, then the slave lines, then master 3..7.
  localparam logic [3:0] PRIO_ORDER [16] = '{
    4'd0, 4'd1, 4'd2, 4'd8, 4'd9, 4'd10, 4'd11, 4'd12,
    4'd13, 4'd14, 4'd15, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7
  };

  localparam logic [4:0] PRIO_RANK [17] = '{
    5'd0, 5'd1, 5'd2, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15,
    5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8, 5'd9, 5'd10, 5'd16
  };

  typedef struct packed {
    logic [2:0] action;
    logic       chip;
    logic [7:0] value;
    logic [3:0] irq_line;
    logic       mask_value;
    logic       interrupts_enabled;
  } in_word_t;

  // Decoded word as held between front and back.
  typedef struct packed {
    action_e     op;
    logic        chip;
    logic [7:0]  value;
    logic [3:0]  irq_line;
    logic [15:0] line_bit;
    logic        mask_value;
    logic        interrupts_enabled;
  } cls_word_t;

  typedef struct packed {
    logic [7:0] read_value;
    logic       granted;
    logic [3:0] granted_line;
    logic [7:0] granted_vector;
    logic       status;
  } out_word_t;

  // Highest-priority set line of v, or NO_LINE.
  function automatic logic [4:0] prio_pick(input logic [15:0] v);
    logic [4:0] r;
    r = NO_LINE;
    for (int j = 15; j >= 0; j--) begin
      if (v[PRIO_ORDER[j]]) begin
        r = {1'b0, PRIO_ORDER[j]};
      end
    end
    return r;
  endfunction

endpackage

/* rtl/dcic_front.sv */
`timescale 1ns / 1ps
// dcic_front: decodes incoming words and holds them in a two-entry queue
// for the back end. Depends on dcic_pkg.
module dcic_front import dcic_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  in_word_t  in_word_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      empty_o,
  output cls_word_t cls_o
);

  cls_word_t  mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  cls_word_t  dec;
  logic       do_push, do_pop;

  always_comb begin
    dec.op                 = action_e'(in_word_i.action);
    dec.chip               = in_word_i.chip;
    dec.value              = in_word_i.value;
    dec.irq_line           = in_word_i.irq_line;
    dec.line_bit           = 16'd1 << in_word_i.irq_line;
    dec.mask_value         = in_word_i.mask_value;
    dec.interrupts_enabled = in_word_i.interrupts_enabled;
  end

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cls_o   = mem_q[rd_ptr_q];

  assign wr_ptr_d = wr_ptr_q ^ do_push;
  assign rd_ptr_d = rd_ptr_q ^ do_pop;
  assign cnt_d    = cnt_q + {1'b0, do_push} - {1'b0, do_pop};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= dec;
    end
  end

endmodule

/* rtl/dcic_resq.sv */
`timescale 1ns / 1ps
// dcic_resq: two-entry result queue in front of the output port.
// Depends on dcic_pkg.
module dcic_resq import dcic_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  out_word_t res_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      empty_o,
  output out_word_t res_o
);

  out_word_t  mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign res_o   = mem_q[rd_ptr_q];

  assign wr_ptr_d = wr_ptr_q ^ do_push;
  assign rd_ptr_d = rd_ptr_q ^ do_pop;
  assign cnt_d    = cnt_q + {1'b0, do_push} - {1'b0, do_pop};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= res_i;
    end
  end

endmodule

/* rtl/dcic_back.sv */
`timescale 1ns / 1ps
// dcic_back: controller state and execution of one decoded word per cycle
// while fire_i is high. Depends on dcic_pkg.
module dcic_back import dcic_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      fire_i,
  input  cls_word_t cls_i,
  output out_word_t res_o
);

  logic [15:0]           req_q, req_d;
  logic [15:0]           msk_q, msk_d;
  logic [15:0]           isr_q, isr_d;
  logic [15:0]           pend_q, pend_d;
  logic [4:0]            cur_q, cur_d;
  logic [1:0][4:0]       vb_q, vb_d;
  init_word_e [1:0]      iwi_q, iwi_d;
  logic [1:0][1:0]       iwc_q, iwc_d;
  logic [1:0]            sngl_q, sngl_d;
  logic [1:0]            aeoi_q, aeoi_d;
  logic [1:0]            rot_q, rot_d;
  logic [1:0]            risr_q, risr_d;
  logic [1:0]            smm_q, smm_d;

  logic        c;
  logic [7:0]  v;
  logic [15:0] isr_closed;
  logic [4:0]  cur_closed;
  logic        do_close;
  logic [4:0]  rank;
  logic        special;
  logic [15:0] elig;
  logic [4:0]  pick;
  logic        gc;
  logic        mask_wr;
  logic [15:0] msk_new, msk_sel, want;

  assign c = cls_i.chip;
  assign v = cls_i.value;

  // Next in-service line once the current one is closed.
  assign isr_closed = isr_q & ~(16'd1 << cur_q[3:0]);
  assign cur_closed = prio_pick(isr_closed);

  // Acknowledge candidates: requested, unmasked lines ranked above the line
  // in service, or any such line of a chip in special mask mode.
  assign rank    = PRIO_RANK[cur_q];
  assign special = smm_q[0] | smm_q[1];

  always_comb begin
    logic [3:0] li;
    for (int i = 0; i < 16; i++) begin
      li = 4'(i);
      elig[i] = ((PRIO_RANK[{1'b0, li}] < rank) || (special && smm_q[li[3]]))
                && !msk_q[li] && req_q[li] && !(li[3] && msk_q[2]);
    end
  end

  assign pick = prio_pick(elig);
  assign gc   = pick[3];

  always_comb begin
    req_d    = req_q;
    msk_d    = msk_q;
    isr_d    = isr_q;
    pend_d   = pend_q;
    cur_d    = cur_q;
    vb_d     = vb_q;
    iwi_d    = iwi_q;
    iwc_d    = iwc_q;
    sngl_d   = sngl_q;
    aeoi_d   = aeoi_q;
    rot_d    = rot_q;
    risr_d   = risr_q;
    smm_d    = smm_q;
    res_o    = '0;
    mask_wr  = 1'b0;
    msk_new  = msk_q;
    msk_sel  = '0;
    do_close = 1'b0;
    want     = '0;

    case (cls_i.op)
      ACT_WR_CMD: begin
        if (v[4]) begin
          // ICW1
          if ((v & 8'hEC) != 8'd0) begin
            res_o.status = 1'b1;
          end else begin
            sngl_d[c] = v[1];
            iwi_d[c]  = IW_ICW2;
            iwc_d[c]  = 2'd2 + {1'b0, v[0]};
          end
        end else if (v[3]) begin
          // OCW3
          if (v[2]) begin
            res_o.status = 1'b1;
          end else begin
            if (v[1]) risr_d[c] = v[0];
            if (v[6]) smm_d[c] = v[5];
          end
        end else if (v[5]) begin
          // EOI, ignored when nothing is in service
          if (v[7]) begin
            res_o.status = 1'b1;
          end else if (!cur_q[4]) begin
            if (v[6]) begin
              do_close = (cur_q == {1'b0, c, v[2:0]});
            end else begin
              do_close = c || !cur_q[3];
            end
          end
        end else if (!v[6]) begin
          rot_d[c] = v[7];
        end
      end

      ACT_WR_DATA: begin
        case (iwi_q[c])
          IW_NONE: begin
            msk_new = c ? {v, msk_q[7:0]} : {msk_q[15:8], v};
            msk_sel = c ? 16'hFF00 : 16'h00FF;
            mask_wr = 1'b1;
          end
          IW_ICW2: begin
            vb_d[c] = v[7:3];
            if (iwc_q[c] < 2'd2) begin
              iwi_d[c] = IW_NONE;
            end else if (sngl_q[c]) begin
              iwi_d[c] = IW_ICW4;
            end else begin
              iwi_d[c] = IW_ICW3;
            end
          end
          IW_ICW3: begin
            iwi_d[c] = (iwc_q[c] < 2'd3) ? IW_NONE : IW_ICW4;
          end
          default: begin
            if (!v[0]) begin
              res_o.status = 1'b1;
            end else begin
              aeoi_d[c] = v[1];
              iwi_d[c]  = IW_NONE;
            end
          end
        endcase
      end

      ACT_RD_CMD: begin
        if (risr_q[c]) begin
          res_o.read_value = c ? isr_q[15:8] : isr_q[7:0];
        end else if (c) begin
          res_o.read_value = req_q[15:8];
        end else begin
          res_o.read_value = req_q[7:0] | {5'd0, (pend_q[15:8] != 8'd0), 2'd0};
        end
      end

      ACT_RD_DATA: begin
        res_o.read_value = c ? msk_q[15:8] : msk_q[7:0];
      end

      ACT_RAISE: begin
        req_d = req_q | cls_i.line_bit;
        if (!msk_q[cls_i.irq_line] && (!cls_i.irq_line[3] || !msk_q[2])) begin
          pend_d = pend_q | cls_i.line_bit;
        end
      end

      ACT_DROP: begin
        req_d  = req_q & ~cls_i.line_bit;
        pend_d = pend_q & ~cls_i.line_bit;
      end

      ACT_SET_MASK: begin
        if (msk_q[cls_i.irq_line] != cls_i.mask_value) begin
          msk_new = msk_q ^ cls_i.line_bit;
          msk_sel = cls_i.line_bit;
          mask_wr = 1'b1;
        end
      end

      ACT_ACK: begin
        if (cls_i.interrupts_enabled && (pend_q != 16'd0) && !pick[4]) begin
          if (aeoi_q[gc] && rot_q[gc]) begin
            res_o.status = 1'b1;
          end else begin
            req_d[pick[3:0]]  = 1'b0;
            pend_d[pick[3:0]] = 1'b0;
            if (!aeoi_q[gc]) begin
              cur_d             = pick;
              isr_d[pick[3:0]] = 1'b1;
            end
            res_o.granted        = 1'b1;
            res_o.granted_line   = pick[3:0];
            res_o.granted_vector = {vb_q[gc], pick[2:0]};
          end
        end
      end

      default: ;
    endcase

    if (do_close) begin
      isr_d = isr_closed;
      cur_d = cur_closed;
    end

    // Mask change: refresh pending bits of the touched lines, and of all
    // slave lines when the cascade line's mask flips.
    if (mask_wr) begin
      if (msk_new[2] != msk_q[2]) msk_sel = msk_sel | 16'hFF00;
      want = req_q & ~msk_new;
      if (msk_new[2]) want[15:8] = 8'd0;
      msk_d  = msk_new;
      pend_d = (pend_q & ~msk_sel) | (want & msk_sel);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_q  <= '0;
      msk_q  <= MASK_RESET;
      isr_q  <= '0;
      pend_q <= '0;
      cur_q  <= NO_LINE;
      vb_q   <= {SLAVE_VBASE, MASTER_VBASE};
      iwi_q  <= '{default: IW_NONE};
      iwc_q  <= '0;
      sngl_q <= '0;
      aeoi_q <= '0;
      rot_q  <= '0;
      risr_q <= '0;
      smm_q  <= '0;
    end else if (fire_i) begin
      req_q  <= req_d;
      msk_q  <= msk_d;
      isr_q  <= isr_d;
      pend_q <= pend_d;
      cur_q  <= cur_d;
      vb_q   <= vb_d;
      iwi_q  <= iwi_d;
      iwc_q  <= iwc_d;
      sngl_q <= sngl_d;
      aeoi_q <= aeoi_d;
      rot_q  <= rot_d;
      risr_q <= risr_d;
      smm_q  <= smm_d;
    end
  end

endmodule

/* rtl/dual_cascaded_interrupt_controller.sv */
`timescale 1ns / 1ps
// Cascaded master/slave pair of 8259-style interrupt controllers; one word
// in (bus access, line event or acknowledge poll) gives one word out (read
// byte, grant with line and vector, or an error flag for unsupported
// commands). Words are taken one per clock while full is low: push and
// full on the input side, empty and pop on the output side. A pushed word
// is registered into the decode queue, and its result into the result
// queue when the execution stage takes it; that stage handles a whole word,
// the 16-line priority pick included, combinationally. Both sides have
// two-entry queues: a stalled reader lets four words stand before full rises.
// Depends on dcic_pkg, dcic_front, dcic_back and dcic_resq.
module dual_cascaded_interrupt_controller import dcic_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  in_word_t  in_word_i,
  output logic      empty,
  input  logic      pop,
  output out_word_t out_word_o
);

  cls_word_t cls;
  out_word_t res;
  logic      mid_empty;
  logic      res_full;
  logic      fire;

  // Front end: decode and queue incoming words.
  dcic_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .in_word_i (in_word_i),
    .full_o    (full),
    .pop_i     (fire),
    .empty_o   (mid_empty),
    .cls_o     (cls)
  );

  // Execute one word whenever one waits and the result queue has room.
  assign fire = !mid_empty && !res_full;

  dcic_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .cls_i  (cls),
    .res_o  (res)
  );

  // Result queue decouples the reader from execution.
  dcic_resq u_resq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fire),
    .res_i   (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .empty_o (empty),
    .res_o   (out_word_o)
  );

endmodule
